/* rtl/core/fbc_pkg.sv */
// Shared types, constants and CRC functions for the frame builder.
package fbc_pkg;

   // Widths of the fixed fields
   localparam int WORD_W = 16;
   localparam int DYN_W = 10;
   localparam int LEN_W = 8;

   // Entries in the queue between front and back end
   localparam int QUEUE_DEPTH = 4;

   // CRC-16/XMODEM generator polynomial
   localparam logic [WORD_W-1:0] CRC_POLY = 16'h1021;

   // Input mode codes
   localparam logic MODE_START = 1'b0;
   localparam logic MODE_WORD = 1'b1;

   typedef enum logic [1:0] {
      STAT_OK = 2'd0,
      STAT_DYN_LIMIT = 2'd1,
      STAT_STRAY = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      OP_START = 3'b001,
      OP_WORD = 3'b010,
      OP_ERR = 3'b100
   } op_kind_type;

   // One classified transaction handed from front to back end
   typedef struct packed {
      op_kind_type kind;
      logic [WORD_W-1:0] node_word;
      logic [WORD_W-1:0] data_word;
      logic uart;
      logic zeros;
      logic crc_en;
      logic close;
      status_type status;
   } op_type;

   function automatic logic [WORD_W-1:0] crc16_byte(input logic [WORD_W-1:0] crc_i,
                                                    input logic [7:0] data_i);
      logic [WORD_W-1:0] c;
      c = crc_i ^ {data_i, 8'h00};
      for (int i = 0; i < 8; i++) begin
         c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
      end
      return c;
   endfunction

   // High byte first, then low byte
   function automatic logic [WORD_W-1:0] crc16_word(input logic [WORD_W-1:0] crc_i,
                                                    input logic [WORD_W-1:0] word_i);
      return crc16_byte(crc16_byte(crc_i, word_i[15:8]), word_i[7:0]);
   endfunction

endpackage

/* rtl/core/frame_builder_crc16.sv */
// Top level of the CRC-16 frame builder: configuration register, front end, queue, back end.
//
// Builds frames of 16-bit words. A start transaction (mode 0) opens a frame and yields an
// optional node word (when uart_framing is set), the header word and, unless the static words
// are supplied, STATIC_WORDS zero words; payload transactions (mode 1) yield one word each. A
// CRC-16/XMODEM word closes the frame when requested, and the final word carries last and the
// frame length. The front end accepts one request per cycle while its 4-entry queue has room;
// the back end emits one response word per cycle unless rsp_ready stalls it; a payload yields
// one word (two when it also closes the frame with a CRC), a start 1 to STATIC_WORDS + 3 words.
// Sustained rate is thus set by the back end's single output register: one word per cycle while
// not stalled. A dynamic count above MAX_FRAME_WORDS - STATIC_WORDS - 2 or a payload outside a
// frame gives a single error response. Write uart_framing only while the block is idle.
module frame_builder_crc16 #(
   parameter int STATIC_WORDS = 4,
   parameter int MAX_FRAME_WORDS = 128
) (
   input  logic clock,
   input  logic reset,
   input  logic csr_wr_en,
   input  logic csr_wr_data,
   input  logic req_valid,
   output logic req_ready,
   input  logic req_mode,
   input  logic [11:0] req_node,
   input  logic [3:0] req_sub_node,
   input  logic [11:0] req_address,
   input  logic [2:0] req_command,
   input  logic req_pending,
   input  logic req_static_given,
   input  logic [fbc_pkg::DYN_W-1:0] req_dyn_count,
   input  logic req_add_crc,
   input  logic [fbc_pkg::WORD_W-1:0] req_word,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [fbc_pkg::WORD_W-1:0] rsp_frame_word,
   output logic rsp_last,
   output logic [1:0] rsp_status,
   output logic [fbc_pkg::LEN_W-1:0] rsp_frame_length
);

   logic uart_framing_ff;
   logic q_full, q_empty, q_push, q_pop;
   fbc_pkg::op_type push_op, head_op;

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         uart_framing_ff <= 1'b0;
      end else if (csr_wr_en) begin
         uart_framing_ff <= csr_wr_data;
      end
   end

   fbc_front #(
      .STATIC_WORDS(STATIC_WORDS),
      .MAX_FRAME_WORDS(MAX_FRAME_WORDS)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .uart_framing(uart_framing_ff),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_mode(req_mode),
      .req_node(req_node),
      .req_sub_node(req_sub_node),
      .req_address(req_address),
      .req_command(req_command),
      .req_pending(req_pending),
      .req_static_given(req_static_given),
      .req_dyn_count(req_dyn_count),
      .req_add_crc(req_add_crc),
      .req_word(req_word),
      .q_full(q_full),
      .q_push(q_push),
      .q_op(push_op)
   );

   fbc_queue #(
      .DEPTH(fbc_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock(clock),
      .reset(reset),
      .push(q_push),
      .push_op(push_op),
      .pop(q_pop),
      .head_op(head_op),
      .full(q_full),
      .empty(q_empty)
   );

   fbc_back #(
      .STATIC_WORDS(STATIC_WORDS)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .head_op(head_op),
      .q_empty(q_empty),
      .q_pop(q_pop),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_frame_word(rsp_frame_word),
      .rsp_last(rsp_last),
      .rsp_status(rsp_status),
      .rsp_frame_length(rsp_frame_length)
   );

endmodule

/* rtl/core/fbc_front.sv */
// Front end: accepts request transactions, tracks frame state, classifies them.
module fbc_front #(
   parameter int STATIC_WORDS = 4,
   parameter int MAX_FRAME_WORDS = 128
) (
   input  logic clock,
   input  logic reset,
   input  logic uart_framing,
   input  logic req_valid,
   output logic req_ready,
   input  logic req_mode,
   input  logic [11:0] req_node,
   input  logic [3:0] req_sub_node,
   input  logic [11:0] req_address,
   input  logic [2:0] req_command,
   input  logic req_pending,
   input  logic req_static_given,
   input  logic [fbc_pkg::DYN_W-1:0] req_dyn_count,
   input  logic req_add_crc,
   input  logic [fbc_pkg::WORD_W-1:0] req_word,
   input  logic q_full,
   output logic q_push,
   output fbc_pkg::op_type q_op
);

   localparam int SW = $clog2(STATIC_WORDS + 1);
   localparam int DYN_LIMIT = MAX_FRAME_WORDS - STATIC_WORDS - 2;

   logic active_ff, active_in;
   logic crc_en_ff, crc_en_in;
   logic [SW-1:0] static_left_ff, static_left_in;
   logic [fbc_pkg::DYN_W-1:0] dyn_left_ff, dyn_left_in;
   logic accept;

   assign req_ready = !q_full;
   assign accept = req_valid && req_ready;
   assign q_push = accept;

   // Classify the transaction and advance the frame counters
   always_comb begin
      active_in = active_ff;
      crc_en_in = crc_en_ff;
      static_left_in = static_left_ff;
      dyn_left_in = dyn_left_ff;
      q_op.kind = fbc_pkg::OP_ERR;
      q_op.node_word = {req_sub_node, req_node};
      q_op.data_word = req_word;
      q_op.uart = uart_framing;
      q_op.zeros = !req_static_given;
      q_op.crc_en = crc_en_ff;
      q_op.close = 1'b0;
      q_op.status = fbc_pkg::STAT_STRAY;
      if (req_mode == fbc_pkg::MODE_START) begin
         q_op.data_word = {req_address, req_command, req_pending};
         if (int'(req_dyn_count) > DYN_LIMIT) begin
            active_in = 1'b0;
            q_op.status = fbc_pkg::STAT_DYN_LIMIT;
         end else begin
            q_op.kind = fbc_pkg::OP_START;
            q_op.status = fbc_pkg::STAT_OK;
            q_op.crc_en = req_add_crc;
            q_op.close = !req_static_given && (req_dyn_count == '0);
            crc_en_in = req_add_crc;
            dyn_left_in = req_dyn_count;
            static_left_in = req_static_given ? SW'(STATIC_WORDS) : '0;
            active_in = !q_op.close;
         end
      end else if (active_ff) begin
         q_op.kind = fbc_pkg::OP_WORD;
         q_op.status = fbc_pkg::STAT_OK;
         if (static_left_ff != '0) begin
            static_left_in = static_left_ff - 1'b1;
         end else if (dyn_left_ff != '0) begin
            dyn_left_in = dyn_left_ff - 1'b1;
         end
         q_op.close = (static_left_in == '0) && (dyn_left_in == '0);
         active_in = !q_op.close;
      end
   end

   // Hold frame state, update on accept
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         crc_en_ff <= 1'b0;
         static_left_ff <= '0;
         dyn_left_ff <= '0;
      end else if (accept) begin
         active_ff <= active_in;
         crc_en_ff <= crc_en_in;
         static_left_ff <= static_left_in;
         dyn_left_ff <= dyn_left_in;
      end
   end

endmodule

/* rtl/core/fbc_queue.sv */
// Small register queue of classified transactions between front and back end.
module fbc_queue #(
   parameter int DEPTH = 4
) (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  fbc_pkg::op_type push_op,
   input  logic pop,
   output fbc_pkg::op_type head_op,
   output logic full,
   output logic empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   fbc_pkg::op_type entry_ff [DEPTH];
   logic [AW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [AW:0] count_ff;

   assign full = (count_ff == (AW + 1)'(DEPTH));
   assign empty = (count_ff == '0);
   assign head_op = entry_ff[rd_ptr_ff];

   // Store pushed entries
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_op;
      end
   end

   // Advance pointers and occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

/* rtl/core/fbc_back.sv */
// Back end: expands queued transactions into frame words, runs the CRC, drives responses.
module fbc_back #(
   parameter int STATIC_WORDS = 4
) (
   input  logic clock,
   input  logic reset,
   input  fbc_pkg::op_type head_op,
   input  logic q_empty,
   output logic q_pop,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [fbc_pkg::WORD_W-1:0] rsp_frame_word,
   output logic rsp_last,
   output logic [1:0] rsp_status,
   output logic [fbc_pkg::LEN_W-1:0] rsp_frame_length
);

   localparam int ZW = (STATIC_WORDS > 1) ? $clog2(STATIC_WORDS) : 1;

   typedef enum logic [5:0] {
      PH_NODE = 6'b000001,
      PH_HEAD = 6'b000010,
      PH_ZERO = 6'b000100,
      PH_WORD = 6'b001000,
      PH_CRC  = 6'b010000,
      PH_ERR  = 6'b100000
   } phase_type;

   phase_type phase_ff, phase_in, first_phase, cur_phase;
   logic active_ff;
   logic [ZW-1:0] zcnt_ff;
   logic [fbc_pkg::WORD_W-1:0] crc_ff, crc_base;
   logic [fbc_pkg::LEN_W-1:0] cnt_ff, cnt_base;
   logic new_frame, advance, emit, done, err, tail_crc, closing;
   logic [fbc_pkg::WORD_W-1:0] word;

   logic rsp_valid_ff;
   logic [fbc_pkg::WORD_W-1:0] word_ff;
   logic last_ff;
   fbc_pkg::status_type status_ff, status_in;
   logic [fbc_pkg::LEN_W-1:0] len_ff, len_in;

   assign advance = !rsp_valid_ff || rsp_ready;
   assign emit = advance && !q_empty;
   assign q_pop = emit && done;

   // Pick the phase of a fresh transaction
   always_comb begin
      case (head_op.kind)
         fbc_pkg::OP_START: first_phase = head_op.uart ? PH_NODE : PH_HEAD;
         fbc_pkg::OP_WORD: first_phase = PH_WORD;
         default: first_phase = PH_ERR;
      endcase
   end

   assign cur_phase = active_ff ? phase_ff : first_phase;
   assign new_frame = !active_ff && (head_op.kind == fbc_pkg::OP_START);
   assign crc_base = new_frame ? '0 : crc_ff;
   assign cnt_base = new_frame ? '0 : cnt_ff;
   assign tail_crc = head_op.close && head_op.crc_en;

   // Select the word for this phase and the phase after it
   always_comb begin
      word = '0;
      done = 1'b1;
      err = 1'b0;
      phase_in = cur_phase;
      case (cur_phase)
         PH_NODE: begin
            word = head_op.node_word;
            done = 1'b0;
            phase_in = PH_HEAD;
         end
         PH_HEAD: begin
            word = head_op.data_word;
            if (head_op.zeros) begin
               done = 1'b0;
               phase_in = PH_ZERO;
            end else if (tail_crc) begin
               done = 1'b0;
               phase_in = PH_CRC;
            end
         end
         PH_ZERO: begin
            if (zcnt_ff != ZW'(STATIC_WORDS - 1)) begin
               done = 1'b0;
            end else if (tail_crc) begin
               done = 1'b0;
               phase_in = PH_CRC;
            end
         end
         PH_WORD: begin
            word = head_op.data_word;
            if (tail_crc) begin
               done = 1'b0;
               phase_in = PH_CRC;
            end
         end
         PH_CRC: word = crc_base;
         PH_ERR: err = 1'b1;
         default: err = 1'b1;
      endcase
   end

   // Mark the frame end or the error
   assign closing = done && head_op.close && !err;
   assign status_in = err ? head_op.status : fbc_pkg::STAT_OK;
   assign len_in = closing ? cnt_base + 1'b1 : '0;

   // Step through the transaction and fold words into the CRC
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         phase_ff <= PH_HEAD;
         zcnt_ff <= '0;
         crc_ff <= '0;
         cnt_ff <= '0;
      end else if (emit) begin
         active_ff <= !done;
         phase_ff <= phase_in;
         zcnt_ff <= (cur_phase == PH_ZERO) ? zcnt_ff + 1'b1 : '0;
         if (!err) begin
            crc_ff <= fbc_pkg::crc16_word(crc_base, word);
            cnt_ff <= cnt_base + 1'b1;
         end
      end
   end

   // Output register: hold while stalled, load on advance
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= !q_empty;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         word_ff <= word;
         last_ff <= err || closing;
         status_ff <= status_in;
         len_ff <= len_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_frame_word = word_ff;
   assign rsp_last = last_ff;
   assign rsp_status = status_ff;
   assign rsp_frame_length = len_ff;

endmodule

/* rtl/core/fbc_checker.sv */
// Port-level checker for the frame builder, bound to the top level.
module fbc_checker (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [15:0] rsp_frame_word,
   input logic rsp_last,
   input logic [1:0] rsp_status,
   input logic [7:0] rsp_frame_length
);

   // Stalled response holds
   rsp_hold_a: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_frame_word) && $stable(rsp_last)
         && $stable(rsp_status) && $stable(rsp_frame_length))
      else $error("response changed while stalled");

   // Length only on the closing word
   len_on_last_a: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_frame_length == 8'd0)
      else $error("frame length on a non-final word");

   // Errors are single zero words marked last, without a length
   err_word_a: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != 2'd0 |-> rsp_last && rsp_frame_word == 16'd0
         && rsp_frame_length == 8'd0)
      else $error("malformed error response");

   // No response right after reset
   reset_quiet_a: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind frame_builder_crc16 fbc_checker u_fbc_checker (
   .clock(clock),
   .reset(reset),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_frame_word(rsp_frame_word),
   .rsp_last(rsp_last),
   .rsp_status(rsp_status),
   .rsp_frame_length(rsp_frame_length)
);
